// File: design/uartlrt_pkg.sv
// Shared types and constants for the 8N1 line receiver and transmitter.
package uartlrt_pkg;

	// Frame format and field widths.
	localparam int DataBits = 8;
	localparam int ByteW    = 8;
	localparam int BitIdxW  = $clog2(DataBits + 1);
	localparam int TimerW   = 16;
	localparam int WaitW    = 32;
	localparam int CountW   = 8;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;
	localparam int SDataW   = 16;
	localparam int MDataW   = 24;

	// Character codes used by the line terminator test.
	localparam logic [ByteW-1:0] CharCr = 8'h0D;
	localparam logic [ByteW-1:0] CharLf = 8'h0A;
	localparam logic [CountW-1:0] CountMax = 8'hFF;

	// Register reset values.
	localparam logic [TimerW-1:0] BitPeriodRst  = 16'd1667;
	localparam logic [WaitW-1:0]  RxTimeoutRst  = 32'd0;
	localparam logic [ByteW-1:0]  TermCharRst   = 8'd10;
	localparam logic [CountW-1:0] MaxLengthRst  = 8'd255;

	typedef enum logic [1:0] {
		CMD_TICK      = 2'd0,
		CMD_SEND      = 2'd1,
		CMD_READ_BYTE = 2'd2,
		CMD_READ_LINE = 2'd3
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_BIT_PERIOD = 3'd0,
		CFG_RX_TIMEOUT = 3'd1,
		CFG_TERM_SEL   = 3'd2,
		CFG_TERM_CHAR  = 3'd3,
		CFG_MAX_LENGTH = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		TX_IDLE  = 2'd0,
		TX_START = 2'd1,
		TX_DATA  = 2'd2,
		TX_STOP  = 2'd3
	} tx_phase_t;

	typedef enum logic [2:0] {
		RX_IDLE  = 3'd0,
		RX_ARMED = 3'd1,
		RX_HALF  = 3'd2,
		RX_DATA  = 3'd3,
		RX_STOP  = 3'd4
	} rx_phase_t;

endpackage

// File: design/uart_8n1_line_receiver_transmitter.sv
// Top level: 8N1 serial transmitter and line receiver, one item per bit-timing tick.
// Path: an accepted item passes the input register, then the result register, and its
// result is held there while the output side stalls.
// Throughput: one item per cycle unless the output stalls; the whole tick of both state
// machines is one pass of logic between the input register and the result register.
// Reset: arst_n clears both state machines to idle, the line level to high, the
// configuration to its defaults and both channel registers to empty.
module uart_8n1_line_receiver_transmitter
	import uartlrt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// cmd [1:0], tx_byte [9:2], rx_pin [10], zero fill above
	input  logic [SDataW-1:0]   s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// tx_line [0], tx_busy [1], rx_busy [2], byte_valid [3], rx_byte [11:4],
	// timed_out [12], char_count [20:13], zero fill above
	output logic [MDataW-1:0]   m_tdata,
	// line_end
	output logic                m_tlast,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	// Configuration registers.
	logic [TimerW-1:0] bit_period_q;
	logic [WaitW-1:0]  rx_timeout_q;
	logic              term_select_q;
	logic [ByteW-1:0]  term_char_q;
	logic [CountW-1:0] max_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q  <= BitPeriodRst;
			rx_timeout_q  <= RxTimeoutRst;
			term_select_q <= 1'b0;
			term_char_q   <= TermCharRst;
			max_length_q  <= MaxLengthRst;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BIT_PERIOD: bit_period_q  <= cfg_data[TimerW-1:0];
				CFG_RX_TIMEOUT: rx_timeout_q  <= cfg_data[WaitW-1:0];
				CFG_TERM_SEL:   term_select_q <= cfg_data[0];
				CFG_TERM_CHAR:  term_char_q   <= cfg_data[ByteW-1:0];
				CFG_MAX_LENGTH: max_length_q  <= cfg_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	// Input register stage.
	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [ByteW-1:0] tx_byte_s1;
	logic             rx_pin_s1;
	logic             advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1     <= cmd_t'(s_tdata[1:0]);
			tx_byte_s1 <= s_tdata[9:2];
			rx_pin_s1  <= s_tdata[10];
		end
	end

	// Machine state.
	tx_phase_t            tx_phase_q;
	logic [DataBits-1:0]  tx_shift_q;
	logic [BitIdxW-1:0]   tx_bit_index_q;
	logic [TimerW-1:0]    tx_timer_q;
	rx_phase_t            rx_phase_q;
	logic [TimerW-1:0]    rx_timer_q;
	logic [DataBits-1:0]  rx_shift_q;
	logic [BitIdxW-1:0]   rx_bit_index_q;
	logic [WaitW-1:0]     wait_counter_q;
	logic                 last_rx_level_q;
	logic                 line_mode_q;
	logic [CountW-1:0]    line_count_q;

	tx_phase_t            tx_phase_d;
	logic [DataBits-1:0]  tx_shift_d;
	logic [BitIdxW-1:0]   tx_bit_index_d;
	logic [TimerW-1:0]    tx_timer_d;
	rx_phase_t            rx_phase_d;
	logic [TimerW-1:0]    rx_timer_d;
	logic [DataBits-1:0]  rx_shift_d;
	logic [BitIdxW-1:0]   rx_bit_index_d;
	logic [WaitW-1:0]     wait_counter_d;
	logic [CountW-1:0]    line_count_d;

	// Transmitter view of this tick, after a send command has loaded a frame.
	logic                      tx_load;
	tx_phase_t                 tx_ph;
	logic [TimerW-1:0]         tx_tmr;
	logic [DataBits-1:0]       tx_sh;
	logic [BitIdxW-1:0]        tx_idx;
	logic [BitIdxW-1:0]        tx_idx_inc;
	logic [DataBits+ByteW-1:0] tx_ext;
	logic                      tx_done;
	logic [TimerW-1:0]         tx_tmr_nx;

	assign tx_load    = (cmd_s1 == CMD_SEND) && (tx_phase_q == TX_IDLE);
	assign tx_ext     = {{DataBits{1'b0}}, tx_byte_s1};
	assign tx_ph      = tx_load ? TX_START : tx_phase_q;
	assign tx_tmr     = tx_load ? '0 : tx_timer_q;
	assign tx_sh      = tx_load ? tx_ext[DataBits-1:0] : tx_shift_q;
	assign tx_idx     = tx_load ? '0 : tx_bit_index_q;
	assign tx_idx_inc = tx_idx + 1'b1;
	assign tx_done    = ({1'b0, tx_tmr} + 1'b1) >= {1'b0, bit_period_q};
	assign tx_tmr_nx  = tx_done ? '0 : tx_tmr + 1'b1;

	// Receiver view of this tick, after an arm command.
	logic                      rx_arm_cmd;
	rx_phase_t                 rx_ph;
	logic [TimerW-1:0]         rx_tmr;
	logic [WaitW-1:0]          rx_wait;
	logic                      rx_lmode;
	logic [CountW-1:0]         rx_lcount;
	logic [CountW-1:0]         rx_lcount_inc;
	logic [CountW-1:0]         rx_limit;
	logic [TimerW-1:0]         rx_lim;
	logic                      rx_done;
	logic [TimerW-1:0]         rx_tmr_nx;
	logic [BitIdxW-1:0]        rx_idx_inc;
	logic                      start_edge;
	logic                      tout_hit;
	logic [DataBits+ByteW-1:0] rx_ext;
	logic [ByteW-1:0]          rx_b;
	logic                      is_term;
	logic                      byte_done;
	logic                      line_done;

	assign rx_arm_cmd = ((cmd_s1 == CMD_READ_BYTE) || (cmd_s1 == CMD_READ_LINE))
		&& (rx_phase_q == RX_IDLE);
	assign rx_ph      = rx_arm_cmd ? RX_ARMED : rx_phase_q;
	assign rx_tmr     = rx_arm_cmd ? '0 : rx_timer_q;
	assign rx_wait    = rx_arm_cmd ? '0 : wait_counter_q;
	assign rx_lmode   = rx_arm_cmd ? (cmd_s1 == CMD_READ_LINE) : line_mode_q;
	assign rx_lcount  = rx_arm_cmd ? '0 : line_count_q;

	// The half-bit wait runs on half the period.
	assign rx_lim     = (rx_ph == RX_HALF) ? {1'b0, bit_period_q[TimerW-1:1]} : bit_period_q;
	assign rx_done    = ({1'b0, rx_tmr} + 1'b1) >= {1'b0, rx_lim};
	assign rx_tmr_nx  = rx_done ? '0 : rx_tmr + 1'b1;
	assign rx_idx_inc = rx_bit_index_q + 1'b1;

	// A start edge is a falling pin against the previous tick's level.
	assign start_edge = last_rx_level_q && !rx_pin_s1;
	assign tout_hit   = !start_edge && (rx_timeout_q != '0) && (rx_wait >= rx_timeout_q);

	// Received byte and line end test.
	assign rx_ext        = {{ByteW{1'b0}}, rx_shift_q};
	assign rx_b          = rx_ext[ByteW-1:0];
	assign is_term       = term_select_q ? (rx_b == term_char_q)
		: ((rx_b == CharCr) || (rx_b == CharLf));
	assign rx_lcount_inc = (rx_lcount != CountMax) ? rx_lcount + 1'b1 : rx_lcount;
	assign rx_limit      = (max_length_q != '0) ? max_length_q : CountW'(1);
	assign byte_done     = (rx_ph == RX_STOP) && rx_done;
	assign line_done     = !rx_lmode || is_term || (rx_lcount_inc >= rx_limit);

	// Next state of the transmitter.
	always_comb begin
		tx_phase_d     = tx_ph;
		tx_shift_d     = tx_sh;
		tx_bit_index_d = tx_idx;
		tx_timer_d     = tx_tmr;
		unique case (tx_ph)
			TX_IDLE: ;
			TX_START: begin
				tx_timer_d = tx_tmr_nx;
				if (tx_done) begin
					tx_phase_d     = TX_DATA;
					tx_bit_index_d = '0;
				end
			end
			TX_DATA: begin
				tx_timer_d = tx_tmr_nx;
				if (tx_done) begin
					tx_shift_d     = tx_sh >> 1;
					tx_bit_index_d = tx_idx_inc;
					if (tx_idx_inc >= BitIdxW'(DataBits)) begin
						tx_phase_d = TX_STOP;
					end
				end
			end
			TX_STOP: begin
				tx_timer_d = tx_tmr_nx;
				if (tx_done) begin
					tx_phase_d = TX_IDLE;
				end
			end
			default: tx_phase_d = TX_IDLE;
		endcase
	end

	// Next state of the receiver.
	always_comb begin
		rx_phase_d     = rx_ph;
		rx_timer_d     = rx_tmr;
		rx_shift_d     = rx_shift_q;
		rx_bit_index_d = rx_bit_index_q;
		wait_counter_d = rx_wait;
		line_count_d   = rx_lcount;
		unique case (rx_ph)
			RX_IDLE: ;
			RX_ARMED: begin
				if (start_edge) begin
					rx_phase_d = RX_HALF;
					rx_timer_d = '0;
				end else if (tout_hit) begin
					rx_phase_d = RX_IDLE;
				end else if (rx_wait != '1) begin
					wait_counter_d = rx_wait + 1'b1;
				end
			end
			RX_HALF: begin
				rx_timer_d = rx_tmr_nx;
				if (rx_done) begin
					rx_phase_d     = RX_DATA;
					rx_bit_index_d = '0;
					rx_shift_d     = '0;
				end
			end
			RX_DATA: begin
				rx_timer_d = rx_tmr_nx;
				if (rx_done) begin
					rx_shift_d     = {rx_pin_s1, rx_shift_q[DataBits-1:1]};
					rx_bit_index_d = rx_idx_inc;
					if (rx_idx_inc >= BitIdxW'(DataBits)) begin
						rx_phase_d = RX_STOP;
					end
				end
			end
			RX_STOP: begin
				rx_timer_d = rx_tmr_nx;
				if (rx_done) begin
					line_count_d = rx_lcount_inc;
					if (line_done) begin
						rx_phase_d = RX_IDLE;
					end else begin
						// Re-arm for the next byte of the line.
						rx_phase_d     = RX_ARMED;
						rx_timer_d     = '0;
						wait_counter_d = '0;
					end
				end
			end
			default: rx_phase_d = RX_IDLE;
		endcase
	end

	// Result fields of this tick.
	logic              tx_line;
	logic              timed_out;
	logic              line_end;
	logic [ByteW-1:0]  rx_byte;
	logic [CountW-1:0] char_count;

	always_comb begin
		unique case (tx_ph)
			TX_START: tx_line = 1'b0;
			TX_DATA:  tx_line = tx_sh[0];
			default:  tx_line = 1'b1;
		endcase
		timed_out  = (rx_ph == RX_ARMED) && tout_hit;
		line_end   = timed_out || (byte_done && line_done);
		rx_byte    = byte_done ? rx_b : '0;
		char_count = '0;
		if (byte_done && line_done) begin
			char_count = rx_lmode ? rx_lcount_inc : CountW'(1);
		end
	end

	// State registers advance once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_phase_q      <= TX_IDLE;
			tx_shift_q      <= '0;
			tx_bit_index_q  <= '0;
			tx_timer_q      <= '0;
			rx_phase_q      <= RX_IDLE;
			rx_timer_q      <= '0;
			rx_shift_q      <= '0;
			rx_bit_index_q  <= '0;
			wait_counter_q  <= '0;
			last_rx_level_q <= 1'b1;
			line_mode_q     <= 1'b0;
			line_count_q    <= '0;
		end else if (advance) begin
			tx_phase_q      <= tx_phase_d;
			tx_shift_q      <= tx_shift_d;
			tx_bit_index_q  <= tx_bit_index_d;
			tx_timer_q      <= tx_timer_d;
			rx_phase_q      <= rx_phase_d;
			rx_timer_q      <= rx_timer_d;
			rx_shift_q      <= rx_shift_d;
			rx_bit_index_q  <= rx_bit_index_d;
			wait_counter_q  <= wait_counter_d;
			last_rx_level_q <= rx_pin_s1;
			line_mode_q     <= rx_lmode;
			line_count_q    <= line_count_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {3'b000, char_count, timed_out, rx_byte, byte_done,
				(rx_phase_d != RX_IDLE), (tx_phase_d != TX_IDLE), tx_line};
			m_tlast <= line_end;
		end
	end

	// A timeout result carries no byte and a zero count.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> m_tlast && !m_tdata[3] && (m_tdata[20:13] == '0))
		else $error("timeout result carries byte or count");

	// A nonzero count only comes with the end of a read.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[20:13] != '0) |-> m_tlast && m_tdata[3])
		else $error("count without line end");

	// Bit counters never pass the frame width.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rx_bit_index_q <= BitIdxW'(DataBits)) && (tx_bit_index_q <= BitIdxW'(DataBits)))
		else $error("bit index out of range");

	// Every processed tick lands in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("processed tick lost");

	// The receiver is idle right after a line end.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && line_end |=> rx_phase_q == RX_IDLE)
		else $error("receiver busy after line end");

endmodule

// File: tb/uart_8n1_line_receiver_transmitter_tb.sv
// Self-checking testbench for the 8N1 serial transmitter and line receiver.
module uart_8n1_line_receiver_transmitter_tb;
	import uartlrt_pkg::*;

	localparam int StuckLimit = 2000;

	// One bit-timing tick as it travels on s_tdata, cmd in the lowest bits.
	typedef struct packed {
		logic             rx_pin;
		logic [ByteW-1:0] tx_byte;
		cmd_t             cmd;
	} tick_t;

	// One line status; the low bits follow the m_tdata layout, line_end rides on tlast.
	typedef struct packed {
		logic              line_end;
		logic [CountW-1:0] char_count;
		logic              timed_out;
		logic [ByteW-1:0]  rx_byte;
		logic              byte_valid;
		logic              rx_busy;
		logic              tx_busy;
		logic              tx_line;
	} status_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SDataW-1:0]   s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [MDataW-1:0]   m_tdata;
	logic                m_tlast;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	tick_t   tick_q[$];
	status_t due_status_q[$];
	status_t due_now;
	status_t seen_now;
	int      mismatch_count = 0;
	int      stuck_cycles = 0;
	int      send_idle_pct = 0;
	int      stall_pct = 0;

	// Mirror of the configuration registers.
	logic [TimerW-1:0] cfg_period;
	logic [WaitW-1:0]  cfg_timeout;
	logic              cfg_term_sel;
	logic [ByteW-1:0]  cfg_term_char;
	logic [CountW-1:0] cfg_max_len;

	// Mirror of the transmitter and receiver state.
	tx_phase_t          tx_ph;
	logic [DataBits-1:0] tx_sr;
	logic [BitIdxW-1:0] tx_bits;
	logic [TimerW-1:0]  tx_cnt;
	rx_phase_t          rx_ph;
	logic [TimerW-1:0]  rx_cnt;
	logic [DataBits-1:0] rx_sr;
	logic [BitIdxW-1:0] rx_bits;
	logic [WaitW-1:0]   idle_wait;
	logic               pin_prev;
	logic               in_line;
	logic [CountW-1:0]  got_bytes;

	uart_8n1_line_receiver_transmitter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void uart_clear();
		cfg_period = BitPeriodRst;
		cfg_timeout = RxTimeoutRst;
		cfg_term_sel = 1'b0;
		cfg_term_char = TermCharRst;
		cfg_max_len = MaxLengthRst;
		tx_ph = TX_IDLE;
		tx_sr = '0;
		tx_bits = '0;
		tx_cnt = '0;
		rx_ph = RX_IDLE;
		rx_cnt = '0;
		rx_sr = '0;
		rx_bits = '0;
		idle_wait = '0;
		pin_prev = 1'b1;
		in_line = 1'b0;
		got_bytes = '0;
	endfunction

	// A bit ends on the tick where its counter reaches the limit; a limit below two ends
	// it at once.
	function automatic logic bit_elapsed(inout logic [TimerW-1:0] cnt,
			input logic [TimerW-1:0] lim);
		if (cnt + 17'd1 >= {1'b0, lim}) begin
			cnt = '0;
			return 1'b1;
		end
		cnt = cnt + 1'b1;
		return 1'b0;
	endfunction

	// Advances both state machines by one tick and returns the line status after it.
	function automatic status_t uart_tick(tick_t t);
		status_t            s;
		logic [WaitW:0]     next_wait;
		logic [CountW-1:0]  line_limit;
		logic               term_hit;
		s = '0;
		s.tx_line = 1'b1;

		// Transmitter: start bit, data LSB first, stop bit.
		if (t.cmd == CMD_SEND && tx_ph == TX_IDLE) begin
			tx_sr = t.tx_byte;
			tx_bits = '0;
			tx_cnt = '0;
			tx_ph = TX_START;
		end
		case (tx_ph)
			TX_START: begin
				s.tx_line = 1'b0;
				if (bit_elapsed(tx_cnt, cfg_period)) begin
					tx_ph = TX_DATA;
					tx_bits = '0;
				end
			end
			TX_DATA: begin
				s.tx_line = tx_sr[0];
				if (bit_elapsed(tx_cnt, cfg_period)) begin
					tx_sr = tx_sr >> 1;
					tx_bits = tx_bits + 1'b1;
					if (tx_bits >= DataBits)
						tx_ph = TX_STOP;
				end
			end
			TX_STOP: begin
				if (bit_elapsed(tx_cnt, cfg_period))
					tx_ph = TX_IDLE;
			end
			default: ;
		endcase

		// Receiver: arming, then edge or timeout, half bit, data bits, stop bit.
		if ((t.cmd == CMD_READ_BYTE || t.cmd == CMD_READ_LINE) && rx_ph == RX_IDLE) begin
			in_line = (t.cmd == CMD_READ_LINE);
			got_bytes = '0;
			rx_ph = RX_ARMED;
			rx_cnt = '0;
			idle_wait = '0;
		end
		case (rx_ph)
			RX_IDLE: ;
			RX_ARMED: begin
				if (pin_prev && !t.rx_pin) begin
					rx_ph = RX_HALF;
					rx_cnt = '0;
				end else begin
					next_wait = {1'b0, idle_wait} + 1'b1;
					if (cfg_timeout != '0 && next_wait > {1'b0, cfg_timeout}) begin
						rx_ph = RX_IDLE;
						s.line_end = 1'b1;
						s.timed_out = 1'b1;
					end else begin
						idle_wait = next_wait[WaitW] ? '1 : next_wait[WaitW-1:0];
					end
				end
			end
			RX_HALF: begin
				if (bit_elapsed(rx_cnt, cfg_period >> 1)) begin
					rx_ph = RX_DATA;
					rx_bits = '0;
					rx_sr = '0;
				end
			end
			RX_DATA: begin
				if (bit_elapsed(rx_cnt, cfg_period)) begin
					rx_sr = {t.rx_pin, rx_sr[DataBits-1:1]};
					rx_bits = rx_bits + 1'b1;
					if (rx_bits >= DataBits)
						rx_ph = RX_STOP;
				end
			end
			RX_STOP: begin
				if (bit_elapsed(rx_cnt, cfg_period)) begin
					s.byte_valid = 1'b1;
					s.rx_byte = rx_sr[ByteW-1:0];
					if (got_bytes != CountMax)
						got_bytes = got_bytes + 1'b1;
					if (!in_line) begin
						rx_ph = RX_IDLE;
						s.line_end = 1'b1;
						s.char_count = CountW'(1);
					end else begin
						term_hit = cfg_term_sel ? (s.rx_byte == cfg_term_char)
							: (s.rx_byte == CharCr || s.rx_byte == CharLf);
						line_limit = (cfg_max_len == '0) ? CountW'(1) : cfg_max_len;
						if (term_hit || got_bytes >= line_limit) begin
							rx_ph = RX_IDLE;
							s.line_end = 1'b1;
							s.char_count = got_bytes;
						end else begin
							rx_ph = RX_ARMED;
							rx_cnt = '0;
							idle_wait = '0;
						end
					end
				end
			end
			default: rx_ph = RX_IDLE;
		endcase
		pin_prev = t.rx_pin;

		s.tx_busy = (tx_ph != TX_IDLE);
		s.rx_busy = (rx_ph != RX_IDLE);
		return s;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Driver: a taken item steps the mirror, then the next item is offered or the bus idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				due_status_q.push_back(uart_tick(tick_t'(s_tdata[$bits(tick_t)-1:0])));
			if (!s_tvalid || s_tready) begin
				if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tdata <= SDataW'(tick_q.pop_front());
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: each taken status is compared with the oldest one due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_status_q.size() == 0) begin
					$display("%0t: status item with none due: actual %0h", $time,
						{m_tlast, m_tdata});
					mismatch_count++;
				end else begin
					due_now = due_status_q.pop_front();
					seen_now = status_t'({m_tlast, m_tdata[$bits(status_t)-2:0]});
					check_field("tx_line", due_now.tx_line, seen_now.tx_line);
					check_field("tx_busy", due_now.tx_busy, seen_now.tx_busy);
					check_field("rx_busy", due_now.rx_busy, seen_now.rx_busy);
					check_field("byte_valid", due_now.byte_valid, seen_now.byte_valid);
					check_field("rx_byte", due_now.rx_byte, seen_now.rx_byte);
					check_field("line_end", due_now.line_end, seen_now.line_end);
					check_field("timed_out", due_now.timed_out, seen_now.timed_out);
					check_field("char_count", due_now.char_count, seen_now.char_count);
				end
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: work is pending but neither side has moved an item for too long.
	always @(posedge clk) begin
		if (arst_n && (tick_q.size() != 0 || s_tvalid || due_status_q.size() != 0)
				&& !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= StuckLimit) begin
				$display("%0t: no item moved for %0d cycles", $time, stuck_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end else begin
			stuck_cycles <= 0;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BIT_PERIOD: cfg_period = val[TimerW-1:0];
			CFG_RX_TIMEOUT: cfg_timeout = val[WaitW-1:0];
			CFG_TERM_SEL:   cfg_term_sel = val[0];
			CFG_TERM_CHAR:  cfg_term_char = val[ByteW-1:0];
			CFG_MAX_LENGTH: cfg_max_len = val[CountW-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [TimerW-1:0] period, logic [WaitW-1:0] timeout,
			logic term_sel, logic [ByteW-1:0] term_char, logic [CountW-1:0] max_len);
		write_reg(CFG_BIT_PERIOD, CfgDataW'(period));
		write_reg(CFG_RX_TIMEOUT, CfgDataW'(timeout));
		write_reg(CFG_TERM_SEL, CfgDataW'(term_sel));
		write_reg(CFG_TERM_CHAR, CfgDataW'(term_char));
		write_reg(CFG_MAX_LENGTH, CfgDataW'(max_len));
	endtask

	task automatic put_tick(cmd_t c, logic [ByteW-1:0] b, logic pin);
		tick_t t;
		t.cmd = c;
		t.tx_byte = b;
		t.rx_pin = pin;
		tick_q.push_back(t);
	endtask

	// A line level for one tick, with an occasional stray command on top.
	task automatic put_level(logic pin);
		int unsigned r;
		cmd_t        c;
		r = $urandom_range(99);
		c = (r < 3) ? CMD_SEND : (r < 4) ? CMD_READ_BYTE : (r < 5) ? CMD_READ_LINE : CMD_TICK;
		put_tick(c, ByteW'($urandom_range(255)), pin);
	endtask

	task automatic put_bits(logic pin, int unsigned n);
		repeat (n) put_level(pin);
	endtask

	task automatic put_frame(logic [ByteW-1:0] b, int unsigned bt, logic stop_level);
		put_bits(1'b0, bt);
		for (int i = 0; i < ByteW; i++)
			put_bits(b[i], bt);
		put_bits(stop_level, bt);
	endtask

	// Line ends show up often so that lines end on the terminator as well as the limit.
	function automatic logic [ByteW-1:0] pick_byte(logic [ByteW-1:0] term_char);
		case ($urandom_range(7))
			0: return CharCr;
			1: return CharLf;
			2: return term_char;
			default: return ByteW'($urandom_range(255));
		endcase
	endfunction

	// Mostly well-formed reads of random bytes; the rest is noise, idle line, glitches
	// and sends.
	task automatic add_chunk(logic [TimerW-1:0] period, logic [ByteW-1:0] term_char);
		int unsigned bt;
		int unsigned r;
		bt = (period < 2) ? 1 : period;
		r = (period > 64) ? 12 : $urandom_range(19);
		if (r < 12) begin
			put_tick(($urandom_range(3) == 0) ? CMD_READ_BYTE : CMD_READ_LINE,
				ByteW'($urandom_range(255)), 1'b1);
			repeat ($urandom_range(1, 5)) begin
				put_bits(1'b1, $urandom_range(0, 2 * bt));
				put_frame(pick_byte(term_char), bt, $urandom_range(7) != 0);
			end
			put_bits(1'b1, bt);
		end else if (r < 14) begin
			repeat ($urandom_range(4, 24)) put_level(1'($urandom_range(1)));
		end else if (r < 16) begin
			if ($urandom_range(1))
				put_tick(CMD_READ_LINE, ByteW'($urandom_range(255)), 1'b1);
			put_bits(1'b1, $urandom_range(1, 4 * bt + 40));
		end else if (r < 17) begin
			put_bits(1'b0, $urandom_range(1, bt));
			put_bits(1'b1, bt * $urandom_range(1, 12));
		end else begin
			put_tick(CMD_SEND, ByteW'($urandom_range(255)), 1'b1);
			put_bits(1'b1, $urandom_range(bt, 12 * bt));
		end
	endtask

	// Waits until every tick is taken and every status has come back.
	task automatic drain();
		while (tick_q.size() != 0 || s_tvalid || due_status_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(logic [TimerW-1:0] period, logic [WaitW-1:0] timeout,
			logic term_sel, logic [ByteW-1:0] term_char, logic [CountW-1:0] max_len,
			int budget, int send_idle, int stall);
		write_all(period, timeout, term_sel, term_char, max_len);
		send_idle_pct = send_idle;
		stall_pct = stall;
		@(negedge clk);
		while (tick_q.size() < budget)
			add_chunk(period, term_char);
		drain();
	endtask

	initial begin
		uart_clear();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: a send, a send while busy, an edge on the arming tick and an
		// arm while the receiver is busy.
		put_tick(CMD_SEND, 8'hFF, 1'b1);
		put_tick(CMD_SEND, 8'h00, 1'b1);
		put_tick(CMD_READ_BYTE, 8'h00, 1'b0);
		put_tick(CMD_READ_LINE, 8'hFF, 1'b0);
		put_tick(CMD_TICK, 8'hAA, 1'b1);
		drain();

		// One-tick bits finish the pending frames, then a read times out on its second tick.
		write_all(16'd1, 32'd1, 1'b1, 8'hFF, 8'd0);
		@(negedge clk);
		repeat (10) put_tick(CMD_TICK, 8'h00, 1'b1);
		put_tick(CMD_READ_LINE, 8'h55, 1'b1);
		put_tick(CMD_TICK, 8'h00, 1'b1);
		drain();

		// Random phases over a range of settings and idling patterns.
		run_phase(16'd2, 32'd0, 1'b0, 8'h0A, 8'd255, 300, 0, 0);
		run_phase(16'd4, 32'd0, 1'b1, 8'h5A, 8'd4, 300, 85, 0);
		run_phase(16'd3, 32'd25, 1'b0, 8'h0D, 8'd255, 300, 0, 85);
		run_phase(16'hFFFF, 32'd3, 1'b1, 8'h00, 8'd2, 30, 37, 37);
		run_phase(16'd5, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'd1, 300, 0, 0);
		run_phase(16'd0, 32'd7, 1'b0, 8'h0A, 8'd0, 240, 85, 0);
		run_phase(16'd6, 32'd60, 1'b1, 8'h41, 8'd3, 240, 0, 85);
		run_phase(16'd2, 32'd12, 1'b0, 8'h0A, 8'd255, 240, 37, 37);

		if (due_status_q.size() != 0) begin
			$display("%0t: %0d status items never arrived", $time, due_status_q.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: files.f
design/uartlrt_pkg.sv
design/uart_8n1_line_receiver_transmitter.sv
tb/uart_8n1_line_receiver_transmitter_tb.sv
